/* sv/lvs_pkg.sv */
// Shared constants, codes and types of the light volume scale block.
`timescale 1ns / 1ps
package lvs_pkg;

  localparam int FRAC_W    = 16;
  localparam int VAL_W     = 32;
  localparam int CUT_W     = 17;
  localparam int CFG_IDX_W = 1;

  // Divider: saturating quotient of a 66-bit dividend by a 33-bit divisor
  localparam int QUO_W    = 48;
  localparam int DEN_W    = 33;
  localparam int NUM_W    = 66;
  localparam int DIV_STEP = 4;
  localparam int DIV_STG  = QUO_W / DIV_STEP;

  // Square root of the discriminant
  localparam int RAD_W     = 84;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int SQRT_STEP = 3;
  localparam int SQRT_STG  = ROOT_W / SQRT_STEP;

  localparam int DIFF_W = 50;

  localparam logic [QUO_W-1:0] D_MAX        = '1;
  localparam logic [CUT_W-1:0] CUTOFF_RESET = CUT_W'(1311);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUTOFF = 1'b0,
    REG_CAP    = 1'b1
  } lvs_reg_e;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_SPOT  = 2'd1
  } lvs_kind_e;

  // Per-light sideband that travels along the pipeline
  typedef struct packed {
    logic [1:0]               kind;
    logic                     bad_kind;
    logic                     empty;
    logic                     unbounded;
    logic                     zero_reach;
    logic signed [VAL_W-1:0]  c;
    logic signed [VAL_W-1:0]  l;
    logic signed [VAL_W-1:0]  q;
    logic [VAL_W-1:0]         tan;
    logic signed [DIFF_W-1:0] diff;
  } lvs_side_t;

  typedef struct packed {
    logic [VAL_W-1:0] scale_x;
    logic [VAL_W-1:0] scale_y;
    logic [VAL_W-1:0] scale_z;
    logic             unbounded;
    logic             bad_kind;
  } lvs_res_t;

endpackage

/* sv/lvs_in_if.sv */
// Light input channel.
`timescale 1ns / 1ps
interface lvs_in_if import lvs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              light_kind;
  logic signed [VAL_W-1:0] constant_term;
  logic signed [VAL_W-1:0] linear_term;
  logic signed [VAL_W-1:0] quadratic_term;
  logic [VAL_W-1:0]        color_red;
  logic [VAL_W-1:0]        color_green;
  logic [VAL_W-1:0]        color_blue;
  logic [VAL_W-1:0]        intensity;
  logic [VAL_W-1:0]        cone_tangent;

  modport source (
    output valid, light_kind, constant_term, linear_term, quadratic_term,
           color_red, color_green, color_blue, intensity, cone_tangent,
    input  ready
  );
  modport sink (
    input  valid, light_kind, constant_term, linear_term, quadratic_term,
           color_red, color_green, color_blue, intensity, cone_tangent,
    output ready
  );
  modport monitor (
    input  valid, ready, light_kind, constant_term, linear_term, quadratic_term,
           color_red, color_green, color_blue, intensity, cone_tangent
  );
endinterface

/* sv/lvs_out_if.sv */
// Scale result channel.
`timescale 1ns / 1ps
interface lvs_out_if import lvs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] scale_x;
  logic [VAL_W-1:0] scale_y;
  logic [VAL_W-1:0] scale_z;
  logic             unbounded;
  logic             bad_kind;

  modport source (
    output valid, scale_x, scale_y, scale_z, unbounded, bad_kind,
    input  ready
  );
  modport sink (
    input  valid, scale_x, scale_y, scale_z, unbounded, bad_kind,
    output ready
  );
  modport monitor (
    input  valid, ready, scale_x, scale_y, scale_z, unbounded, bad_kind
  );
endinterface

/* sv/lvs_cfg_if.sv */
// Configuration write channel.
`timescale 1ns / 1ps
interface lvs_cfg_if import lvs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VAL_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

/* sv/lvs_div.sv */
// Pipelined restoring divider with a quotient saturated at D_MAX.
`timescale 1ns / 1ps
module lvs_div import lvs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  lvs_side_t        side_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o,
  output lvs_side_t        side_o
);

  logic             v_q    [DIV_STG];
  logic             sat_q  [DIV_STG];
  logic [DEN_W-1:0] rem_q  [DIV_STG];
  logic [QUO_W-1:0] low_q  [DIV_STG];
  logic [QUO_W-1:0] quo_q  [DIV_STG];
  logic [DEN_W-1:0] den_q  [DIV_STG];
  lvs_side_t        side_q [DIV_STG];

  logic in_sat;

  // Quotient does not fit in QUO_W bits
  assign in_sat = {{(DEN_W + QUO_W - NUM_W){1'b0}}, num_i} >= {den_i, {QUO_W{1'b0}}};

  for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
    logic             vin, sin;
    logic [DEN_W-1:0] rin, din, rnx;
    logic [QUO_W-1:0] lin, qin, lnx, qnx;
    lvs_side_t        sdin;

    if (s == 0) begin : g_head
      assign vin  = valid_i;
      assign sin  = in_sat;
      assign rin  = DEN_W'(num_i[NUM_W-1:QUO_W]);
      assign lin  = num_i[QUO_W-1:0];
      assign qin  = '0;
      assign din  = den_i;
      assign sdin = side_i;
    end else begin : g_body
      assign vin  = v_q[s-1];
      assign sin  = sat_q[s-1];
      assign rin  = rem_q[s-1];
      assign lin  = low_q[s-1];
      assign qin  = quo_q[s-1];
      assign din  = den_q[s-1];
      assign sdin = side_q[s-1];
    end

    // Retire DIV_STEP quotient bits
    always_comb begin
      logic [DEN_W:0] wide;
      rnx = rin;
      lnx = lin;
      qnx = qin;
      for (int j = 0; j < DIV_STEP; j++) begin
        wide = {rnx, lnx[QUO_W-1]};
        lnx  = {lnx[QUO_W-2:0], 1'b0};
        if (wide >= {1'b0, din}) begin
          wide = wide - {1'b0, din};
          qnx  = {qnx[QUO_W-2:0], 1'b1};
        end else begin
          qnx  = {qnx[QUO_W-2:0], 1'b0};
        end
        rnx = wide[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (adv_i) begin
        v_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        sat_q[s]  <= sin;
        rem_q[s]  <= rnx;
        low_q[s]  <= lnx;
        quo_q[s]  <= qnx;
        den_q[s]  <= din;
        side_q[s] <= sdin;
      end
    end
  end

  assign valid_o = v_q[DIV_STG-1];
  assign quo_o   = sat_q[DIV_STG-1] ? D_MAX : quo_q[DIV_STG-1];
  assign side_o  = side_q[DIV_STG-1];

endmodule

/* sv/lvs_sqrt.sv */
// Pipelined digit-by-digit integer square root, floor of the exact root.
`timescale 1ns / 1ps
module lvs_sqrt import lvs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  lvs_side_t         side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output lvs_side_t         side_o
);

  logic              v_q    [SQRT_STG];
  logic [ROOT_W+1:0] rem_q  [SQRT_STG];
  logic [RAD_W-1:0]  rad_q  [SQRT_STG];
  logic [ROOT_W-1:0] root_q [SQRT_STG];
  lvs_side_t         side_q [SQRT_STG];

  for (genvar s = 0; s < SQRT_STG; s++) begin : g_stg
    logic              vin;
    logic [ROOT_W+1:0] rin, rnx;
    logic [RAD_W-1:0]  ain, anx;
    logic [ROOT_W-1:0] oin, onx;
    lvs_side_t         sdin;

    if (s == 0) begin : g_head
      assign vin  = valid_i;
      assign rin  = '0;
      assign ain  = rad_i;
      assign oin  = '0;
      assign sdin = side_i;
    end else begin : g_body
      assign vin  = v_q[s-1];
      assign rin  = rem_q[s-1];
      assign ain  = rad_q[s-1];
      assign oin  = root_q[s-1];
      assign sdin = side_q[s-1];
    end

    // Resolve SQRT_STEP root bits, two radicand bits each
    always_comb begin
      logic [ROOT_W+3:0] t;
      logic [ROOT_W+3:0] trial;
      rnx = rin;
      anx = ain;
      onx = oin;
      for (int j = 0; j < SQRT_STEP; j++) begin
        t     = {rnx, anx[RAD_W-1:RAD_W-2]};
        anx   = {anx[RAD_W-3:0], 2'b00};
        trial = {2'b00, onx, 2'b01};
        if (t >= trial) begin
          t   = t - trial;
          onx = {onx[ROOT_W-2:0], 1'b1};
        end else begin
          onx = {onx[ROOT_W-2:0], 1'b0};
        end
        rnx = t[ROOT_W+1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (adv_i) begin
        v_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s]  <= rnx;
        rad_q[s]  <= anx;
        root_q[s] <= onx;
        side_q[s] <= sdin;
      end
    end
  end

  assign valid_o = v_q[SQRT_STG-1];
  assign root_o  = root_q[SQRT_STG-1];
  assign side_o  = side_q[SQRT_STG-1];

endmodule

/* sv/lvs_disc.sv */
// Discriminant stages: ratio minus c, products, sum and sign resolution.
`timescale 1ns / 1ps
module lvs_disc import lvs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [QUO_W-1:0] ratio_i,
  input  lvs_side_t        side_i,
  output logic             valid_o,
  output logic [RAD_W-1:0] disc_o,
  output lvs_side_t        side_o
);

  logic c_v_q, d_v_q, e_v_q, f_v_q;
  lvs_side_t c_side_q, d_side_q, e_side_q, f_side_q;

  logic signed [DIFF_W-1:0] diff_d;
  logic [DIFF_W-1:0]        ndiff;
  logic [DIFF_W-2:0]        dabs_d, c_dabs_q;
  logic [VAL_W-1:0]         labs_d, c_labs_q;
  lvs_side_t                c_side_d;

  logic [2*VAL_W-1:0]       d_l2_q, e_l2_q;
  logic [2*VAL_W-2:0]       d_pl_q;
  logic [VAL_W+15:0]        d_ph_q;

  logic [RAD_W-5:0]         psum_d;
  logic [RAD_W-1:0]         e_p_q;

  logic [RAD_W-1:0]         l2w, add_d, sub_d, disc_d, f_disc_q;
  logic                     q_pos, neg, unb_d;
  lvs_side_t                f_side_d;

  // Stage C: signed difference and magnitudes
  always_comb begin
    diff_d = $signed({2'b00, ratio_i})
           - $signed({{(DIFF_W-VAL_W){side_i.c[VAL_W-1]}}, side_i.c});
    ndiff  = -diff_d;
    dabs_d = diff_d[DIFF_W-1] ? ndiff[DIFF_W-2:0] : diff_d[DIFF_W-2:0];
    labs_d = side_i.l[VAL_W-1] ? VAL_W'(-side_i.l) : VAL_W'(side_i.l);
    c_side_d       = side_i;
    c_side_d.diff  = diff_d;
    c_side_d.empty = (ratio_i[QUO_W-1:FRAC_W] == '0);
  end

  // Stage E: recombine the split product of q and |diff|, times four
  assign psum_d = {{(RAD_W-4-(2*VAL_W-1)){1'b0}}, d_pl_q} + {d_ph_q, {VAL_W{1'b0}}};

  // Stage F: form the discriminant or flag the reach as unbounded
  always_comb begin
    q_pos = !e_side_q.q[VAL_W-1] && (e_side_q.q != '0);
    neg   = e_side_q.diff[DIFF_W-1];
    l2w   = {{(RAD_W-2*VAL_W){1'b0}}, e_l2_q};
    add_d = l2w + e_p_q;
    sub_d = l2w - e_p_q;
    if (q_pos) begin
      if (!neg) begin
        disc_d = add_d;
        unb_d  = 1'b0;
      end else if (e_p_q <= l2w) begin
        disc_d = sub_d;
        unb_d  = 1'b0;
      end else begin
        disc_d = '0;
        unb_d  = 1'b1;
      end
    end else begin
      disc_d = '0;
      unb_d  = e_side_q.l[VAL_W-1] || (e_side_q.l == '0) || neg;
    end
    f_side_d           = e_side_q;
    f_side_d.unbounded = unb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
    end else if (adv_i) begin
      c_v_q <= valid_i;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_side_q <= c_side_d;
      c_dabs_q <= dabs_d;
      c_labs_q <= labs_d;
      d_side_q <= c_side_q;
      d_l2_q   <= c_labs_q * c_labs_q;
      d_pl_q   <= c_side_q.q[VAL_W-2:0] * c_dabs_q[VAL_W-1:0];
      d_ph_q   <= c_side_q.q[VAL_W-2:0] * c_dabs_q[DIFF_W-2:VAL_W];
      e_side_q <= d_side_q;
      e_l2_q   <= d_l2_q;
      e_p_q    <= {2'b00, psum_d, 2'b00};
      f_side_q <= f_side_d;
      f_disc_q <= disc_d;
    end
  end

  assign valid_o = f_v_q;
  assign disc_o  = f_disc_q;
  assign side_o  = f_side_q;

endmodule

/* sv/lvs_scale.sv */
// Reach selection and cap, spot radius products, saturated result register.
`timescale 1ns / 1ps
module lvs_scale import lvs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [QUO_W-1:0] quo_i,
  input  lvs_side_t        side_i,
  input  logic [VAL_W-1:0] cap_i,
  output logic             valid_o,
  output lvs_res_t         res_o
);

  logic h_v_q, i_v_q, j_v_q;
  lvs_side_t h_side_q, i_side_q;
  logic [QUO_W-1:0]   reach_d, h_reach_q;
  logic [2*VAL_W-1:0] i_hi_q;
  logic [VAL_W+15:0]  i_lo_q;
  logic [VAL_W-1:0]   i_z_q, rad_d;
  logic [VAL_W:0]     rsum;
  lvs_res_t           res_d, res_q;

  // Stage H: pick the reach and apply the cap
  always_comb begin
    if (side_i.unbounded) begin
      reach_d = D_MAX;
    end else if (side_i.zero_reach) begin
      reach_d = '0;
    end else begin
      reach_d = quo_i;
    end
    if ((cap_i != '1) && (reach_d > {{(QUO_W-VAL_W){1'b0}}, cap_i})) begin
      reach_d = {{(QUO_W-VAL_W){1'b0}}, cap_i};
    end
  end

  // Stage J: saturate the spot radius and assemble the result
  always_comb begin
    rsum = {1'b0, i_hi_q[VAL_W-1:0]} + {1'b0, i_lo_q[VAL_W+15:FRAC_W]};
    if (i_hi_q[2*VAL_W-1:VAL_W] != '0 || rsum[VAL_W]) begin
      rad_d = '1;
    end else begin
      rad_d = rsum[VAL_W-1:0];
    end
    res_d = '0;
    if (i_side_q.bad_kind) begin
      res_d.bad_kind = 1'b1;
    end else if (!i_side_q.empty) begin
      res_d.scale_z   = i_z_q;
      res_d.unbounded = i_side_q.unbounded;
      if (i_side_q.kind == KIND_POINT) begin
        res_d.scale_x = i_z_q;
        res_d.scale_y = i_z_q;
      end else begin
        res_d.scale_x = rad_d;
        res_d.scale_y = rad_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_v_q <= 1'b0;
      i_v_q <= 1'b0;
      j_v_q <= 1'b0;
    end else if (adv_i) begin
      h_v_q <= valid_i;
      i_v_q <= h_v_q;
      j_v_q <= i_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      h_side_q  <= side_i;
      h_reach_q <= reach_d;
      i_side_q  <= h_side_q;
      i_hi_q    <= h_side_q.tan * h_reach_q[QUO_W-1:FRAC_W];
      i_lo_q    <= h_side_q.tan * h_reach_q[FRAC_W-1:0];
      i_z_q     <= (h_reach_q[QUO_W-1:VAL_W] != '0) ? '1 : h_reach_q[VAL_W-1:0];
      res_q     <= res_d;
    end
  end

  assign valid_o = j_v_q;
  assign res_o   = res_q;

endmodule

/* sv/light_volume_scale_core.sv */
// Top level of the light volume scale pipeline.
`timescale 1ns / 1ps
// Takes one light per clock and returns its volume scales in
// Q16.16: two front stages (largest color channel, peak product), a 12-stage
// divider for peak over cutoff, four discriminant stages, a 14-stage square
// root, one operand select stage, a second 12-stage divider for the reach and
// three stages for cap, spot radius and the output register. Every stage moves
// together, so a stall on the result side holds the whole pipe and throughput
// is one light per cycle whenever results are taken. Write cutoff_level and
// distance_cap only while no light is in flight.
module light_volume_scale_core import lvs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  lvs_in_if.sink   light_i,
  lvs_cfg_if.sink  cfg_i,
  lvs_out_if.source scale_o
);

  logic             adv;
  logic [CUT_W-1:0] cut_q, cut_eff;
  logic [VAL_W-1:0] cap_q;

  logic               a_v_q, b_v_q;
  lvs_side_t          a_side_d, a_side_q, b_side_q;
  logic [VAL_W-1:0]   a_inten_q, a_cmax_q, cmax_d;
  logic [2*VAL_W-1:0] peak_prod;
  logic [QUO_W-1:0]   b_peak_q;

  logic             d1_v;
  logic [QUO_W-1:0] ratio;
  lvs_side_t        d1_side;

  logic             ds_v;
  logic [RAD_W-1:0] disc;
  lvs_side_t        ds_side;

  logic              sq_v;
  logic [ROOT_W-1:0] root;
  lvs_side_t         sq_side;

  logic signed [ROOT_W+1:0] num_d;
  logic                     q_pos;
  lvs_side_t                g_side_d, g_side_q;
  logic [NUM_W-1:0]         g_num_d, g_num_q;
  logic [DEN_W-1:0]         g_den_d, g_den_q;
  logic                     g_v_q;

  logic             d2_v;
  logic [QUO_W-1:0] reach;
  lvs_side_t        d2_side;

  logic     res_v;
  lvs_res_t res;

  // Advance the whole pipe unless a result is waiting
  assign adv           = !res_v || scale_o.ready;
  assign light_i.ready = adv;
  assign cfg_i.ready   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q <= CUTOFF_RESET;
      cap_q <= '1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_CUTOFF: cut_q <= cfg_i.data[CUT_W-1:0];
        REG_CAP:    cap_q <= cfg_i.data;
        default:    ;
      endcase
    end
  end

  assign cut_eff = (cut_q == '0) ? CUT_W'(1) : cut_q;

  // Stage A: largest color channel and sideband capture
  always_comb begin
    cmax_d = (light_i.color_red > light_i.color_green) ? light_i.color_red
                                                      : light_i.color_green;
    if (light_i.color_blue > cmax_d) begin
      cmax_d = light_i.color_blue;
    end
    a_side_d            = '0;
    a_side_d.kind       = light_i.light_kind;
    a_side_d.bad_kind   = light_i.light_kind > KIND_SPOT;
    a_side_d.c          = light_i.constant_term;
    a_side_d.l          = light_i.linear_term;
    a_side_d.q          = light_i.quadratic_term;
    a_side_d.tan        = light_i.cone_tangent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      g_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= light_i.valid;
      b_v_q <= a_v_q;
      g_v_q <= sq_v;
    end
  end

  // Full 64-bit product of intensity and the largest channel
  assign peak_prod = a_inten_q * a_cmax_q;

  // Stage B: peak level in Q32.16, low product bits truncated
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_side_q  <= a_side_d;
      a_inten_q <= light_i.intensity;
      a_cmax_q  <= cmax_d;
      b_side_q  <= a_side_q;
      b_peak_q  <= peak_prod[QUO_W+FRAC_W-1:FRAC_W];
    end
  end

  // Ratio of peak over cutoff
  lvs_div u_div_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (b_v_q),
    .num_i   ({{(NUM_W-QUO_W-FRAC_W){1'b0}}, b_peak_q, {FRAC_W{1'b0}}}),
    .den_i   ({{(DEN_W-CUT_W){1'b0}}, cut_eff}),
    .side_i  (b_side_q),
    .valid_o (d1_v),
    .quo_o   (ratio),
    .side_o  (d1_side)
  );

  lvs_disc u_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (d1_v),
    .ratio_i (ratio),
    .side_i  (d1_side),
    .valid_o (ds_v),
    .disc_o  (disc),
    .side_o  (ds_side)
  );

  lvs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (ds_v),
    .rad_i   (disc),
    .side_i  (ds_side),
    .valid_o (sq_v),
    .root_o  (root),
    .side_o  (sq_side)
  );

  // Stage G: select quadratic or linear operands for the reach divide
  always_comb begin
    q_pos = !sq_side.q[VAL_W-1] && (sq_side.q != '0);
    num_d = $signed({2'b00, root})
          - $signed({{(ROOT_W+2-VAL_W){sq_side.l[VAL_W-1]}}, sq_side.l});
    g_side_d = sq_side;
    if (q_pos) begin
      g_side_d.zero_reach = num_d[ROOT_W+1] || (num_d == '0);
      g_num_d = {{(NUM_W-ROOT_W-1-FRAC_W){1'b0}}, num_d[ROOT_W:0], {FRAC_W{1'b0}}};
      g_den_d = {1'b0, sq_side.q[VAL_W-2:0], 1'b0};
    end else begin
      g_side_d.zero_reach = 1'b0;
      g_num_d = {{(NUM_W-DIFF_W+1-FRAC_W){1'b0}}, sq_side.diff[DIFF_W-2:0],
                 {FRAC_W{1'b0}}};
      g_den_d = {1'b0, sq_side.l};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_side_q <= g_side_d;
      g_num_q  <= g_num_d;
      g_den_q  <= g_den_d;
    end
  end

  // Reach distance
  lvs_div u_div_reach (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (g_v_q),
    .num_i   (g_num_q),
    .den_i   (g_den_q),
    .side_i  (g_side_q),
    .valid_o (d2_v),
    .quo_o   (reach),
    .side_o  (d2_side)
  );

  lvs_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (d2_v),
    .quo_i   (reach),
    .side_i  (d2_side),
    .cap_i   (cap_q),
    .valid_o (res_v),
    .res_o   (res)
  );

  assign scale_o.valid     = res_v;
  assign scale_o.scale_x   = res.scale_x;
  assign scale_o.scale_y   = res.scale_y;
  assign scale_o.scale_z   = res.scale_z;
  assign scale_o.unbounded = res.unbounded;
  assign scale_o.bad_kind  = res.bad_kind;

`ifndef NO_ASSERTIONS
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v && res.bad_kind |->
      res.scale_x == '0 && res.scale_y == '0 && res.scale_z == '0 && !res.unbounded)
    else $error("bad kind result carries nonzero scales");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v && !res.bad_kind && cap_q != '1 |-> res.scale_z <= cap_q)
    else $error("reach exceeds distance cap");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(a_v_q) && $stable(g_v_q))
    else $error("pipeline moved during a stall");
`endif

endmodule

/* test/lvs_tb_if.sv */
// Shared testbench constants and the light record type.
`timescale 1ns / 1ps
package lvs_tb_pkg;
  import lvs_pkg::*;

  localparam int CLK_HALF = 6;
  localparam logic [47:0] REACH_MAX = '1;
  localparam logic [31:0] ONES32 = '1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] c;
    logic [31:0] l;
    logic [31:0] q;
    logic [31:0] r;
    logic [31:0] g;
    logic [31:0] b;
    logic [31:0] inten;
    logic [31:0] tan;
  } light_t;
endpackage

/* test/lvs_checker.sv */
// Scale predictor and result scoreboard for the light volume scale block.
`timescale 1ns / 1ps
module lvs_checker import lvs_pkg::*; import lvs_tb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lvs_in_if.monitor   light_i,
  lvs_cfg_if.monitor  cfg_i,
  lvs_out_if.monitor  scale_o,
  output int          fail_count_o,
  output int          pending_o
);
  logic [16:0] cutoff_q;
  logic [31:0] cap_q;
  lvs_res_t    expected_scales[$];

  assign pending_o = expected_scales.size();

  // Integer square root by bit-by-bit search
  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (128'(t) * 128'(t) <= n) r = t;
    end
    return r;
  endfunction

  // Compute the scales for one light under the current registers
  function automatic lvs_res_t predict_scales(light_t li);
    lvs_res_t       res;
    logic [63:0]    cut, cmax, peak, qt, ratio, reach, labs, dabs, k, hi, rad;
    logic signed [63:0] kc, kl, kq, diff, num;
    logic [127:0]   l2, p, disc;
    logic           ok;
    res = '0;
    if (li.kind > 2'd1) begin
      res.bad_kind = 1'b1;
      return res;
    end
    kc = 64'(signed'(li.c));
    kl = 64'(signed'(li.l));
    kq = 64'(signed'(li.q));
    cut = (cutoff_q == 0) ? 64'd1 : 64'(cutoff_q);
    cmax = li.r > li.g ? li.r : li.g;
    if (li.b > cmax) cmax = li.b;
    peak = (64'(li.inten) * cmax) >> 16;
    if (peak < cut) return res;
    qt = peak / cut;
    if (qt >= 64'h1_0000_0000) ratio = 64'(REACH_MAX);
    else ratio = (qt << 16) + (((peak % cut) << 16) / cut);
    if (ratio > 64'(REACH_MAX)) ratio = 64'(REACH_MAX);
    if (kq > 0) begin
      diff = signed'(ratio) - kc;
      labs = kl < 0 ? -kl : kl;
      dabs = diff < 0 ? -diff : diff;
      l2 = 128'(labs) * 128'(labs);
      p = 128'(4 * kq) * 128'(dabs);
      ok = 1'b1;
      if (diff >= 0) disc = l2 + p;
      else if (p <= l2) disc = l2 - p;
      else begin
        ok = 1'b0;
        disc = l2;
      end
      if (!ok) begin
        res.unbounded = 1'b1;
        reach = 64'(REACH_MAX);
      end else begin
        num = signed'(isqrt(disc)) - kl;
        if (num <= 0) reach = 0;
        else reach = (64'(num) << 16) / (2 * 64'(kq));
      end
    end else if (kl <= 0 || signed'(ratio) < kc) begin
      res.unbounded = 1'b1;
      reach = 64'(REACH_MAX);
    end else begin
      k = ratio - kc;
      qt = k / 64'(kl);
      if (qt >= 64'h1_0000_0000) reach = 64'(REACH_MAX);
      else reach = (qt << 16) + (((k % 64'(kl)) << 16) / 64'(kl));
    end
    if (reach > 64'(REACH_MAX)) reach = 64'(REACH_MAX);
    if (cap_q != ONES32 && reach > 64'(cap_q)) reach = 64'(cap_q);
    res.scale_z = reach > 64'(ONES32) ? ONES32 : reach[31:0];
    if (li.kind == KIND_POINT) begin
      res.scale_x = res.scale_z;
    end else begin
      hi = 64'(li.tan) * (reach >> 16);
      if (hi > 64'(ONES32)) rad = 64'(ONES32);
      else rad = hi + ((64'(li.tan) * (reach & 64'hFFFF)) >> 16);
      res.scale_x = rad > 64'(ONES32) ? ONES32 : rad[31:0];
    end
    res.scale_y = res.scale_x;
    return res;
  endfunction

  // Track registers, queue predictions and compare results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    light_t   li;
    lvs_res_t got;
    lvs_res_t exp_r;
    if (!rst_ni) begin
      cutoff_q <= CUTOFF_RESET;
      cap_q <= ONES32;
      fail_count_o <= 0;
      expected_scales.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == REG_CUTOFF) cutoff_q <= cfg_i.data[16:0];
        else cap_q <= cfg_i.data;
      end
      if (light_i.valid && light_i.ready) begin
        li = '{light_i.light_kind, light_i.constant_term, light_i.linear_term,
               light_i.quadratic_term, light_i.color_red, light_i.color_green,
               light_i.color_blue, light_i.intensity, light_i.cone_tangent};
        expected_scales.push_back(predict_scales(li));
      end
      if (scale_o.valid && scale_o.ready) begin
        got = '{scale_o.scale_x, scale_o.scale_y, scale_o.scale_z,
                scale_o.unbounded, scale_o.bad_kind};
        if (expected_scales.size() == 0) begin
          $display("%0t: unexpected scale transaction, got %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_scales.pop_front();
          if (got !== exp_r) begin
            $display("%0t: scale mismatch, expected x=%h y=%h z=%h unb=%b bad=%b",
                     $time, exp_r.scale_x, exp_r.scale_y, exp_r.scale_z,
                     exp_r.unbounded, exp_r.bad_kind);
            $display("%0t:   actual x=%h y=%h z=%h unb=%b bad=%b", $time,
                     got.scale_x, got.scale_y, got.scale_z, got.unbounded,
                     got.bad_kind);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

/* test/tb_top.sv */
// Stimulus and verdict for the light volume scale core.
`timescale 1ns / 1ps
module tb_top import lvs_pkg::*; import lvs_tb_pkg::*; ();
  localparam longint CYCLE_LIMIT = 400000;
  localparam int LATENCY = 48;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  int   hold_off = 0;
  logic hold_go = 1'b0;
  logic hold_taken = 1'b0;
  longint cycles = 0;

  lvs_in_if  light_if ();
  lvs_cfg_if cfg_if ();
  lvs_out_if scale_if ();

  light_volume_scale_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .light_i(light_if.sink), .cfg_i(cfg_if.sink),
    .scale_o(scale_if.source)
  );

  lvs_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .light_i(light_if.monitor),
    .cfg_i(cfg_if.monitor), .scale_o(scale_if.monitor), .fail_count_o(fail_count),
    .pending_o(pending)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Timeout watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("light_volume_scale_core regression: fail");
      $finish;
    end
  end

  // Result side: random stalls plus the long hold-off
  always @(posedge clk_i) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_off <= 300;
      scale_if.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      scale_if.ready <= 1'b0;
    end else begin
      scale_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Offer one light and hold it until accepted
  task automatic send_light(light_t li);
    while ($urandom_range(99) < src_idle_pct) begin
      light_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    light_if.valid <= 1'b1;
    {light_if.light_kind, light_if.constant_term, light_if.linear_term,
     light_if.quadratic_term, light_if.color_red, light_if.color_green,
     light_if.color_blue, light_if.intensity, light_if.cone_tangent} <= li;
    @(posedge clk_i);
    while (!light_if.ready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    light_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(lvs_reg_e idx, logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(32'h4_0000);
      default: return $urandom;
    endcase
  endfunction

  // Mostly plausible lights: small positive terms and moderate colors
  function automatic light_t rand_light();
    light_t li;
    li.kind = ($urandom_range(9) == 0) ? 2'($urandom_range(3, 2))
                                       : 2'($urandom_range(1));
    if ($urandom_range(3) == 0) begin
      li.c = rand_val(); li.l = rand_val(); li.q = rand_val();
      li.r = rand_val(); li.g = rand_val(); li.b = rand_val();
      li.inten = rand_val(); li.tan = rand_val();
    end else begin
      li.c = $urandom_range(32'h2_0000);
      li.l = $urandom_range(32'h1_0000);
      li.q = ($urandom_range(3) == 0) ? 32'h0 : $urandom_range(32'h1_0000);
      li.r = $urandom_range(32'h2_0000);
      li.g = $urandom_range(32'h2_0000);
      li.b = $urandom_range(32'h2_0000);
      li.inten = $urandom_range(32'h8_0000);
      li.tan = $urandom_range(32'h3_0000);
    end
    return li;
  endfunction

  initial begin
    light_t li;
    light_if.valid = 1'b0;
    light_if.light_kind = '0;
    light_if.constant_term = '0;
    light_if.linear_term = '0;
    light_if.quadratic_term = '0;
    light_if.color_red = '0;
    light_if.color_green = '0;
    light_if.color_blue = '0;
    light_if.intensity = '0;
    light_if.cone_tangent = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_CUTOFF;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: invalid kinds, empty volume, quadratic, linear, unbounded, extremes
    send_light('{2'd2, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0,
                 32'h1_0000, 32'h1_0000});
    send_light('{2'd3, 0, 0, 0, '1, '1, '1, '1, '1});
    send_light('{KIND_POINT, 32'h1_0000, 0, 32'h1_0000, 32'h10, 0, 0, 32'h10, 0});
    send_light('{KIND_POINT, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000,
                 32'h8000, 0, 32'h1_0000, 0});
    send_light('{KIND_SPOT, 32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 32'h1_0000, 0,
                 32'h2_0000, 32'h1_0000});
    send_light('{KIND_POINT, 32'h1_0000, 32'h1_0000, 0, 32'h1_0000, 0, 0,
                 32'h1_0000, 0});
    send_light('{KIND_SPOT, 32'h1_0000, 0, 0, 32'h1_0000, 0, 0, 32'h1_0000,
                 32'h1_0000});
    send_light('{KIND_SPOT, 32'h1_0000, 32'h1_0000, 0, 32'h1_0000, 0, 0,
                 32'h1_0000, 0});
    send_light('{KIND_POINT, 32'h7FFF_FFFF, 32'h1_0000, 0, 0, 0, 32'h1_0000,
                 32'h1_0000, 0});
    send_light('{KIND_POINT, 32'h7FFF_FFFF, 32'h1_0000, 32'h1, 32'h1_0000, 0, 0,
                 32'h1_0000, 0});
    send_light('{KIND_POINT, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1_0000, 0, 0,
                 32'h1_0000, 0});
    send_light('{KIND_SPOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, '1,
                 '1, '1, '1});
    send_light('{KIND_SPOT, 32'h8000_0000, 32'h1, 32'h0, '1, 0, 0, '1, '1});
    send_light('{KIND_POINT, 0, 32'h1, 0, '1, '1, '1, '1, 0});
    send_light('{KIND_SPOT, 0, 32'h0, 32'h1, 32'h1_0000, 0, 0, 32'h1_0000, '1});
    drain_results();

    // Zero cutoff, cap, then a cutoff of 0x1_0000 with a zero cap
    write_reg(REG_CUTOFF, 32'h0);
    write_reg(REG_CAP, 32'h8_0000);
    send_light('{KIND_POINT, 32'h1_0000, 32'h1, 0, 32'h1, 0, 0, 32'h1, 0});
    send_light('{KIND_SPOT, 0, 32'h1_0000, 0, '1, 0, 0, '1, '1});
    send_light('{KIND_POINT, 0, 0, 0, 32'h1_0000, 0, 0, 32'h1_0000, 0});
    drain_results();
    write_reg(REG_CUTOFF, 32'h1_0000);
    write_reg(REG_CAP, 32'h0);
    send_light('{KIND_SPOT, 0, 32'h1_0000, 32'h1_0000, 32'h4_0000, 0, 0,
                 32'h4_0000, 32'h2_0000});
    drain_results();

    // Random phases over several register settings and idle mixes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_CUTOFF, 32'd1311); write_reg(REG_CAP, '1); end
        1: begin write_reg(REG_CUTOFF, 32'd1); write_reg(REG_CAP, 32'h20_0000); end
        2: begin write_reg(REG_CUTOFF, $urandom_range(1, 32'h1_0000));
                 write_reg(REG_CAP, $urandom); end
        3: begin write_reg(REG_CUTOFF, 32'h1_0000); write_reg(REG_CAP, '1); end
        4: begin write_reg(REG_CUTOFF, $urandom_range(1, 4000));
                 write_reg(REG_CAP, 32'hFFFF_FFFE); end
        default: begin write_reg(REG_CUTOFF, 32'd1311); write_reg(REG_CAP, '1); end
      endcase
      src_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 57 : 0;
      snk_idle_pct = (ph < 2) ? 57 : (ph < 4) ? 14 : 0;
      if (ph == 4) hold_go <= 1'b1;
      for (int i = 0; i < 150; i++) begin
        li = rand_light();
        send_light(li);
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("light_volume_scale_core regression: pass");
    end else begin
      $display("light_volume_scale_core regression: fail");
    end
    $finish;
  end
endmodule

/* filelist.f */
sv/lvs_pkg.sv
sv/lvs_in_if.sv
sv/lvs_out_if.sv
sv/lvs_cfg_if.sv
sv/lvs_div.sv
sv/lvs_sqrt.sv
sv/lvs_disc.sv
sv/lvs_scale.sv
sv/light_volume_scale_core.sv
test/lvs_tb_if.sv
test/lvs_checker.sv
test/tb_top.sv
